// File: design/ray_sphere_intersect_defines.svh
// Assertion macros for the ray-sphere intersection design; only rsi_fifo uses them.
`ifndef RAY_SPHERE_INTERSECT_DEFINES_SVH
`define RAY_SPHERE_INTERSECT_DEFINES_SVH
`ifndef SYNTHESIS
`define RSI_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("rsi assertion failed");
`define RSI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rsi assertion failed");
`else
`define RSI_ASSERT(lbl, prop)
`define RSI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: design/rsi_pkg.sv
// Types, widths and constants of the ray-sphere intersection block.
package rsi_pkg;

    localparam int RSI_QUEUE_DEPTH = 4;
    localparam int PADDR_W = 5;
    localparam int COORD_W = 32;
    localparam int OC_W = COORD_W + 1;
    localparam int P1_W = 2 * OC_W;
    localparam int SUM_W = 70;
    localparam int PRD_W = 2 * SUM_W;
    localparam int DISC_W = PRD_W + 1;
    localparam int RAD_W = PRD_W;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W = ROOT_W + 2;
    localparam int A_W = 64;
    localparam int S_W = ROOT_W + 2;
    localparam int FRAC_W = 16;
    localparam int MAG_W = S_W + FRAC_W;
    localparam int QS_W = MAG_W + 1;
    localparam int MUL_LAT = 4;
    localparam int MUL_CHUNK_W = 32;
    localparam int FRONT_LAT = 2 * MUL_LAT + 3;
    localparam int BACK_LAT = ROOT_W + MAG_W + 4;

    typedef enum logic [2:0] {
        REG_CENTER_X,
        REG_CENTER_Y,
        REG_CENTER_Z,
        REG_RADIUS,
        REG_MATERIAL
    } t_reg_idx;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] center;
        logic [30:0]             radius;
        logic [7:0]              material;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] t_min;
        logic signed [31:0] t_max;
    } t_ray;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] hit_t;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic [7:0]         hit_material;
    } t_hit;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] org;
        logic [2:0][COORD_W-1:0] dir;
        logic [COORD_W-1:0]      t_min;
        logic [COORD_W-1:0]      t_max;
        logic                    ok;
        logic [A_W-1:0]          a;
    } t_side;

    typedef struct packed {
        t_side                   side;
        logic signed [SUM_W-1:0] h;
        logic [RAD_W-1:0]        rad;
    } t_mid;

endpackage

// File: design/rsi_stream_if.sv
// Valid/ready stream interface carrying one request payload.
interface rsi_stream_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: design/rsi_mul.sv
// Pipelined signed multiplier built from 32x32 partial products.
module rsi_mul #(
    parameter int AW = 33,
    parameter int BW = 33,
    parameter int PW = 66
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [AW-1:0] i_a,
    input  logic signed [BW-1:0] i_b,
    output logic signed [PW-1:0] o_p
);
    import rsi_pkg::*;

    localparam int NA = (AW + MUL_CHUNK_W - 1) / MUL_CHUNK_W;
    localparam int NB = (BW + MUL_CHUNK_W - 1) / MUL_CHUNK_W;
    localparam int AXW = NA * MUL_CHUNK_W;
    localparam int BXW = NB * MUL_CHUNK_W;
    localparam int SW = AXW + BXW;

    logic signed [AXW:0] w_ax;
    logic signed [BXW:0] w_bx;
    logic [AXW:0] w_am;
    logic [BXW:0] w_bm;
    logic [AXW-1:0] r_am;
    logic [BXW-1:0] r_bm;
    logic [2:0] r_sgn;
    logic [2*MUL_CHUNK_W-1:0] r_pp [0:NA-1][0:NB-1];
    logic [SW-1:0] w_sum;
    logic [SW-1:0] r_sum;
    logic [SW-1:0] w_neg;
    logic signed [PW-1:0] r_p;

    assign w_ax = (AXW + 1)'(i_a);
    assign w_bx = (BXW + 1)'(i_b);
    assign w_am = w_ax[AXW] ? -w_ax : w_ax;
    assign w_bm = w_bx[BXW] ? -w_bx : w_bx;

    always_comb begin
        w_sum = '0;
        for (int i = 0; i < NA; i++) begin
            for (int j = 0; j < NB; j++) begin
                w_sum = w_sum + (SW'(r_pp[i][j]) << ((i + j) * MUL_CHUNK_W));
            end
        end
    end

    assign w_neg = r_sgn[2] ? -r_sum : r_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_am <= w_am[AXW-1:0];
            r_bm <= w_bm[BXW-1:0];
            r_sgn <= {r_sgn[1:0], i_a[AW-1] ^ i_b[BW-1]};
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= r_am[i*MUL_CHUNK_W +: MUL_CHUNK_W]
                                  * r_bm[j*MUL_CHUNK_W +: MUL_CHUNK_W];
                end
            end
            r_sum <= w_sum;
            r_p <= w_neg[PW-1:0];
        end
    end

    assign o_p = r_p;
endmodule

// File: design/rsi_front.sv
// Front part: forms the quadratic coefficients and the discriminant of each ray.
module rsi_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rsi_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    input  rsi_pkg::t_ray i_data,
    output logic          o_ready,
    output logic          o_valid,
    output rsi_pkg::t_mid o_data,
    input  logic          i_ready
);
    import rsi_pkg::*;

    logic en;
    logic [FRONT_LAT-1:0] r_vld;
    t_ray r_ray [0:FRONT_LAT-2];
    logic [COORD_W-1:0] w_org [0:2];
    logic [COORD_W-1:0] w_dir [0:2];
    logic signed [OC_W-1:0] w_d [0:2];
    logic signed [OC_W-1:0] w_oc [0:2];
    logic signed [P1_W-1:0] w_dd [0:2];
    logic signed [P1_W-1:0] w_dh [0:2];
    logic signed [P1_W-1:0] w_cc [0:2];
    logic signed [2*COORD_W-1:0] w_rr;
    logic signed [COORD_W-1:0] w_rad_s;
    logic signed [SUM_W-1:0] r_a, r_h, r_c;
    logic signed [SUM_W-1:0] r_ad [0:MUL_LAT-1];
    logic signed [SUM_W-1:0] r_hd [0:MUL_LAT-1];
    logic signed [PRD_W-1:0] w_hh, w_ac;
    logic signed [DISC_W-1:0] w_disc;
    t_ray w_last;
    t_mid r_out;

    assign en = !r_vld[FRONT_LAT-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[FRONT_LAT-1];
    assign o_data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[FRONT_LAT-2:0], i_valid};
        end
    end

    assign w_org[0] = r_ray[0].origin_x;
    assign w_org[1] = r_ray[0].origin_y;
    assign w_org[2] = r_ray[0].origin_z;
    assign w_dir[0] = r_ray[0].dir_x;
    assign w_dir[1] = r_ray[0].dir_y;
    assign w_dir[2] = r_ray[0].dir_z;
    assign w_rad_s = $signed({1'b0, i_cfg.radius});

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_d[i] = OC_W'($signed(w_dir[i]));
            w_oc[i] = OC_W'($signed(w_org[i])) - OC_W'($signed(i_cfg.center[i]));
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_axis
        rsi_mul #(.AW(OC_W), .BW(OC_W), .PW(P1_W)) u_dd (
            .i_clk(i_clk), .i_en(en), .i_a(w_d[i]), .i_b(w_d[i]), .o_p(w_dd[i])
        );
        rsi_mul #(.AW(OC_W), .BW(OC_W), .PW(P1_W)) u_dh (
            .i_clk(i_clk), .i_en(en), .i_a(w_d[i]), .i_b(w_oc[i]), .o_p(w_dh[i])
        );
        rsi_mul #(.AW(OC_W), .BW(OC_W), .PW(P1_W)) u_cc (
            .i_clk(i_clk), .i_en(en), .i_a(w_oc[i]), .i_b(w_oc[i]), .o_p(w_cc[i])
        );
    end

    rsi_mul #(.AW(COORD_W), .BW(COORD_W), .PW(2*COORD_W)) u_rr (
        .i_clk(i_clk), .i_en(en), .i_a(w_rad_s), .i_b(w_rad_s), .o_p(w_rr)
    );

    rsi_mul #(.AW(SUM_W), .BW(SUM_W), .PW(PRD_W)) u_hh (
        .i_clk(i_clk), .i_en(en), .i_a(r_h), .i_b(r_h), .o_p(w_hh)
    );

    rsi_mul #(.AW(SUM_W), .BW(SUM_W), .PW(PRD_W)) u_ac (
        .i_clk(i_clk), .i_en(en), .i_a(r_a), .i_b(r_c), .o_p(w_ac)
    );

    assign w_disc = DISC_W'(w_hh) - DISC_W'(w_ac);
    assign w_last = r_ray[FRONT_LAT-2];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ray[0] <= i_data;
            for (int k = 1; k < FRONT_LAT - 1; k++) begin
                r_ray[k] <= r_ray[k-1];
            end
            r_a <= SUM_W'(w_dd[0]) + SUM_W'(w_dd[1]) + SUM_W'(w_dd[2]);
            r_h <= SUM_W'(w_dh[0]) + SUM_W'(w_dh[1]) + SUM_W'(w_dh[2]);
            r_c <= SUM_W'(w_cc[0]) + SUM_W'(w_cc[1]) + SUM_W'(w_cc[2]) - SUM_W'(w_rr);
            r_ad[0] <= r_a;
            r_hd[0] <= r_h;
            for (int k = 1; k < MUL_LAT; k++) begin
                r_ad[k] <= r_ad[k-1];
                r_hd[k] <= r_hd[k-1];
            end
            r_out.side.org <= {w_last.origin_z, w_last.origin_y, w_last.origin_x};
            r_out.side.dir <= {w_last.dir_z, w_last.dir_y, w_last.dir_x};
            r_out.side.t_min <= w_last.t_min;
            r_out.side.t_max <= w_last.t_max;
            r_out.side.a <= r_ad[MUL_LAT-1][A_W-1:0];
            r_out.side.ok <= !w_disc[DISC_W-1] && (w_disc != '0)
                             && (r_ad[MUL_LAT-1] != '0);
            r_out.h <= r_hd[MUL_LAT-1];
            r_out.rad <= w_disc[RAD_W-1:0];
        end
    end
endmodule

// File: design/rsi_fifo.sv
// Short queue between the front and the back part.
`include "ray_sphere_intersect_defines.svh"
module rsi_fifo #(
    parameter int DEPTH = rsi_pkg::RSI_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  rsi_pkg::t_mid i_data,
    output logic          o_ready,
    output logic          o_valid,
    output rsi_pkg::t_mid o_data,
    input  logic          i_ready
);
    import rsi_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int PTR_W = $clog2(DEPTH);

    t_mid r_mem [0:DEPTH-1];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic w_push, w_pop;

    assign o_ready = r_count != CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data = r_mem[r_rd];
    assign w_push = i_valid && o_ready;
    assign w_pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    `RSI_ASSERT_NEXT(a_push_grows, w_push && !w_pop, r_count == $past(r_count) + 1'b1)
    `RSI_ASSERT_NEXT(a_pop_shrinks, w_pop && !w_push, r_count == $past(r_count) - 1'b1)
    `RSI_ASSERT_NEXT(a_both_hold, w_push && w_pop, $stable(r_count))
endmodule

// File: design/rsi_back.sv
// Back part: square root, division, range test and hit point of each ray.
module rsi_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rsi_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    input  rsi_pkg::t_mid i_data,
    output logic          o_ready,
    output logic          o_valid,
    output rsi_pkg::t_hit o_data,
    input  logic          i_ready
);
    import rsi_pkg::*;

    localparam int PF_W = COORD_W + 18;

    function automatic logic [31:0] sat32(input logic signed [PF_W-1:0] v);
        logic [31:0] res;
        if ((&v[PF_W-1:31]) || !(|v[PF_W-1:31])) begin
            res = v[31:0];
        end else begin
            res = v[PF_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
        end
        return res;
    endfunction

    logic en;
    logic [BACK_LAT-1:0] r_vld;

    logic [REM_W-1:0] r_sq_rem [0:ROOT_W-1];
    logic [ROOT_W-1:0] r_sq_root [0:ROOT_W-1];
    logic [RAD_W-1:0] r_sq_rad [0:ROOT_W-1];
    t_side r_sq_side [0:ROOT_W-1];
    logic signed [SUM_W-1:0] r_sq_h [0:ROOT_W-1];

    logic signed [S_W-1:0] w_s;
    logic [S_W-1:0] w_smag;
    logic r_n_sign;
    logic [MAG_W-1:0] r_n_mag;
    t_side r_n_side;

    logic [A_W-1:0] r_dv_rem [0:MAG_W-1];
    logic [MAG_W-1:0] r_dv_q [0:MAG_W-1];
    logic [MAG_W-1:0] r_dv_num [0:MAG_W-1];
    logic r_dv_sign [0:MAG_W-1];
    t_side r_dv_side [0:MAG_W-1];

    logic signed [QS_W-1:0] w_q;
    logic signed [QS_W-1:0] r_q;
    t_side r_q_side;

    logic r_t_hit;
    logic [COORD_W-1:0] r_t_t;
    logic signed [2*COORD_W-1:0] r_t_prod [0:2];
    t_side r_t_side;

    logic signed [2*COORD_W-1:0] w_fl [0:2];
    logic signed [PF_W-1:0] w_pf [0:2];
    logic signed [PF_W-1:0] w_nrm [0:2];
    t_hit w_res;
    t_hit r_res;

    assign en = !r_vld[BACK_LAT-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[BACK_LAT-1];
    assign o_data = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[BACK_LAT-2:0], i_valid};
        end
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        logic [REM_W-1:0] p_rem;
        logic [ROOT_W-1:0] p_root;
        logic [RAD_W-1:0] p_rad;
        t_side p_side;
        logic signed [SUM_W-1:0] p_h;
        logic [REM_W-1:0] w_rem2, w_trial;
        logic w_ge;

        if (k == 0) begin : g_first
            assign p_rem = '0;
            assign p_root = '0;
            assign p_rad = i_data.rad;
            assign p_side = i_data.side;
            assign p_h = i_data.h;
        end else begin : g_next
            assign p_rem = r_sq_rem[k-1];
            assign p_root = r_sq_root[k-1];
            assign p_rad = r_sq_rad[k-1];
            assign p_side = r_sq_side[k-1];
            assign p_h = r_sq_h[k-1];
        end

        assign w_rem2 = {p_rem[REM_W-3:0], p_rad[RAD_W-1 -: 2]};
        assign w_trial = {p_root, 2'b01};
        assign w_ge = w_rem2 >= w_trial;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_rem[k] <= w_ge ? w_rem2 - w_trial : w_rem2;
                r_sq_root[k] <= {p_root[ROOT_W-2:0], w_ge};
                r_sq_rad[k] <= {p_rad[RAD_W-3:0], 2'b00};
                r_sq_side[k] <= p_side;
                r_sq_h[k] <= p_h;
            end
        end
    end

    assign w_s = -S_W'(r_sq_h[ROOT_W-1]) - $signed(S_W'(r_sq_root[ROOT_W-1]));
    assign w_smag = w_s[S_W-1] ? -w_s : w_s;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n_sign <= w_s[S_W-1];
            r_n_mag <= {w_smag, {FRAC_W{1'b0}}};
            r_n_side <= r_sq_side[ROOT_W-1];
        end
    end

    for (genvar k = 0; k < MAG_W; k++) begin : g_div
        logic [A_W-1:0] p_rem;
        logic [MAG_W-1:0] p_q;
        logic [MAG_W-1:0] p_num;
        logic p_sign;
        t_side p_side;
        logic [A_W:0] w_rem2, w_diff;
        logic w_ge;

        if (k == 0) begin : g_first
            assign p_rem = '0;
            assign p_q = '0;
            assign p_num = r_n_mag;
            assign p_sign = r_n_sign;
            assign p_side = r_n_side;
        end else begin : g_next
            assign p_rem = r_dv_rem[k-1];
            assign p_q = r_dv_q[k-1];
            assign p_num = r_dv_num[k-1];
            assign p_sign = r_dv_sign[k-1];
            assign p_side = r_dv_side[k-1];
        end

        assign w_rem2 = {p_rem, p_num[MAG_W-1]};
        assign w_diff = w_rem2 - {1'b0, p_side.a};
        assign w_ge = w_rem2 >= {1'b0, p_side.a};

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_rem[k] <= w_ge ? w_diff[A_W-1:0] : w_rem2[A_W-1:0];
                r_dv_q[k] <= {p_q[MAG_W-2:0], w_ge};
                r_dv_num[k] <= {p_num[MAG_W-2:0], 1'b0};
                r_dv_sign[k] <= p_sign;
                r_dv_side[k] <= p_side;
            end
        end
    end

    assign w_q = r_dv_sign[MAG_W-1]
               ? -($signed(QS_W'(r_dv_q[MAG_W-1]))
                   + $signed(QS_W'(r_dv_rem[MAG_W-1] != '0)))
               : $signed(QS_W'(r_dv_q[MAG_W-1]));

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_q <= w_q;
            r_q_side <= r_dv_side[MAG_W-1];
            r_t_hit <= r_q_side.ok
                       && (r_q >= QS_W'($signed(r_q_side.t_min)))
                       && (r_q <= QS_W'($signed(r_q_side.t_max)));
            r_t_t <= r_q[COORD_W-1:0];
            for (int i = 0; i < 3; i++) begin
                r_t_prod[i] <= $signed(r_q[COORD_W-1:0]) * $signed(r_q_side.dir[i]);
            end
            r_t_side <= r_q_side;
            r_res <= w_res;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_fl[i] = r_t_prod[i] >>> FRAC_W;
            w_pf[i] = PF_W'($signed(r_t_side.org[i])) + PF_W'(w_fl[i]);
            w_nrm[i] = w_pf[i] - PF_W'($signed(i_cfg.center[i]));
        end
        w_res = '0;
        if (r_t_hit) begin
            w_res.hit = 1'b1;
            w_res.hit_t = r_t_t;
            w_res.point_x = sat32(w_pf[0]);
            w_res.point_y = sat32(w_pf[1]);
            w_res.point_z = sat32(w_pf[2]);
            w_res.normal_x = sat32(w_nrm[0]);
            w_res.normal_y = sat32(w_nrm[1]);
            w_res.normal_z = sat32(w_nrm[2]);
            w_res.hit_material = i_cfg.material;
        end
    end
endmodule

// File: design/ray_sphere_intersect.sv
// Top level of the ray-sphere intersection block with its register port.
// One ray enters per cycle and one result leaves per cycle while the result side accepts; a ray
// passes through the coefficient and discriminant pipeline, the queue and the back pipeline,
// where the square root resolves one root bit per stage (70 stages) and the divider one quotient
// bit per stage (88 stages). When the result side stalls, the back pipeline holds, the queue
// absorbs up to QUEUE_DEPTH rays, and then the front pipeline holds. The user must write the
// sphere registers only while no ray is in flight; the block itself does not enforce this.
module ray_sphere_intersect #(
    parameter int QUEUE_DEPTH = rsi_pkg::RSI_QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [rsi_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    rsi_stream_if.sink                  i_ray,
    rsi_stream_if.source                o_hit
);
    import rsi_pkg::*;

    t_cfg r_cfg;
    t_reg_idx w_idx;
    logic w_wr;
    logic w_f_valid, w_f_ready, w_q_valid, w_q_ready;
    t_mid w_f_data, w_q_data;

    assign pready = 1'b1;
    assign w_idx = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center <= '0;
            r_cfg.radius <= 31'd65536;
            r_cfg.material <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_CENTER_X: r_cfg.center[0] <= pwdata;
                REG_CENTER_Y: r_cfg.center[1] <= pwdata;
                REG_CENTER_Z: r_cfg.center[2] <= pwdata;
                REG_RADIUS:   r_cfg.radius <= pwdata[30:0];
                REG_MATERIAL: r_cfg.material <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_CENTER_X: prdata = r_cfg.center[0];
            REG_CENTER_Y: prdata = r_cfg.center[1];
            REG_CENTER_Z: prdata = r_cfg.center[2];
            REG_RADIUS:   prdata = {1'b0, r_cfg.radius};
            REG_MATERIAL: prdata = {24'd0, r_cfg.material};
            default:      prdata = '0;
        endcase
    end

    rsi_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(i_ray.valid), .i_data(i_ray.data), .o_ready(i_ray.ready),
        .o_valid(w_f_valid), .o_data(w_f_data), .i_ready(w_f_ready)
    );

    rsi_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_f_valid), .i_data(w_f_data), .o_ready(w_f_ready),
        .o_valid(w_q_valid), .o_data(w_q_data), .i_ready(w_q_ready)
    );

    rsi_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(w_q_valid), .i_data(w_q_data), .o_ready(w_q_ready),
        .o_valid(o_hit.valid), .o_data(o_hit.data), .i_ready(o_hit.ready)
    );
endmodule
